FILE: rtl/ultrasonic_ranger_obstacle_stop_assert.svh
// ----------------------------------------------------------------------------
// ultrasonic ranger assertion macros
// immediate-free concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGER_OBSTACLE_STOP_ASSERT_SVH
`define ULTRASONIC_RANGER_OBSTACLE_STOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define URS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urs assertion failed");
// next-cycle implication
`define URS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urs assertion failed");
`else
`define URS_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define URS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg
// shared types and constants of the ultrasonic ranger with obstacle stop
// ----------------------------------------------------------------------------
package urs_pkg;

  localparam int URS_COUNTER_BITS = 20;

  // field widths
  localparam int TIMEOUT_W   = 16;
  localparam int TRIGGER_W   = 8;
  localparam int GAP_W       = 20;
  localparam int SETTLE_W    = 20;
  localparam int THRESH_W    = 11;
  localparam int SPEED_W     = 8;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;
  localparam int STATUS_W    = 2;
  localparam int DIST_W      = 11;
  localparam int DIR_W       = 4;
  localparam int SUB_W       = 6;

  // register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd30000;
  localparam logic [TRIGGER_W-1:0] TRIGGER_RST = 8'd10;
  localparam logic [GAP_W-1:0]     GAP_RST     = 20'd60000;
  localparam logic [SETTLE_W-1:0]  SETTLE_RST  = 20'd100000;
  localparam logic [THRESH_W-1:0]  THRESH_RST  = 11'd20;
  localparam logic [SPEED_W-1:0]   SPEED_RST   = 8'd120;

  // ranging constants
  localparam logic [SUB_W-1:0]  CM_DIV         = 6'd58;
  localparam logic [DIST_W-1:0] CM_MAX         = 11'd2047;
  localparam logic [31:0]       LOW_LEAD_TICKS = 32'd2;
  localparam logic [DIR_W-1:0]  DIR_FORWARD    = 4'b1010;
  localparam logic [DIR_W-1:0]  DIR_STOP       = 4'b0000;

  // measure status codes
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_VALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TIMEOUT = 3'd0,
    CFG_TRIGGER = 3'd1,
    CFG_GAP     = 3'd2,
    CFG_SETTLE  = 3'd3,
    CFG_THRESH  = 3'd4,
    CFG_SPEED   = 3'd5
  } cfg_idx_t;

  typedef enum logic [5:0] {
    PH_SETTLE    = 6'b000001,
    PH_TRIG_LOW  = 6'b000010,
    PH_TRIG_HIGH = 6'b000100,
    PH_WAIT_RISE = 6'b001000,
    PH_TIME_HIGH = 6'b010000,
    PH_GAP       = 6'b100000
  } phase_t;

endpackage

FILE: rtl/urs_in_if.sv
// ----------------------------------------------------------------------------
// urs_in_if
// tick item channel: one sampled echo level per item
// ----------------------------------------------------------------------------
interface urs_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

FILE: rtl/urs_out_if.sv
// ----------------------------------------------------------------------------
// urs_out_if
// result item channel: trigger level, measurement and motor drive per tick
// ----------------------------------------------------------------------------
interface urs_out_if;
  import urs_pkg::*;

  logic                valid;
  logic                ready;
  logic                trigger_level;
  logic [STATUS_W-1:0] measure_status;
  logic [DIST_W-1:0]   range_cm;
  logic                obstacle;
  logic [SPEED_W-1:0]  drive_duty;
  logic [DIR_W-1:0]    direction_bits;

  modport source (output valid, output trigger_level, output measure_status,
                  output range_cm, output obstacle, output drive_duty,
                  output direction_bits, input ready);
  modport sink   (input valid, input trigger_level, input measure_status,
                  input range_cm, input obstacle, input drive_duty,
                  input direction_bits, output ready);
endinterface

FILE: rtl/ultrasonic_ranger_obstacle_stop.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_obstacle_stop
// echo ranging controller that stops both motors when an obstacle is near
// ----------------------------------------------------------------------------
// usage
//   in_ch  : one item per microsecond tick, carrying the sampled echo level
//   out_ch : one result item per input item: trigger level for that tick,
//            measurement status and distance, obstacle flag, motor duty and
//            direction lines
//   cfg_*  : write-only register port (timeout, trigger width, gap, settle, threshold,
//            motor speed), written by the user while the block is idle; not enforced
// result timing and throughput
//   the result of an item is written into the output register at the edge
//   that accepts the item; one item per cycle is sustained while out_ch.ready
//   stays high, since the whole tick update is a short chain of phase compares
//   between the state registers and the result register
// reset
//   the block enters the settle phase with motors stopped and registers at
//   their default values; no result is pending
// stall
//   while a result waits and out_ch.ready is low, in_ch.ready drops and the
//   state holds; a taken result frees the slot in the same cycle
// ----------------------------------------------------------------------------
`include "ultrasonic_ranger_obstacle_stop_assert.svh"

module ultrasonic_ranger_obstacle_stop #(
  parameter int COUNTER_BITS = urs_pkg::URS_COUNTER_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  urs_in_if.sink                          in_ch,
  urs_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [urs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [urs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import urs_pkg::*;

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  // configuration registers
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [TRIGGER_W-1:0] trigger_r;
  logic [GAP_W-1:0]     gap_r;
  logic [SETTLE_W-1:0]  settle_r;
  logic [THRESH_W-1:0]  thresh_r;
  logic [SPEED_W-1:0]   speed_r;

  // ranging state
  phase_t                  phase_r, phase_nxt;
  logic [COUNTER_BITS-1:0] ticks_r, ticks_nxt;
  logic [DIST_W-1:0]       cm_r, cm_nxt;
  logic [SUB_W-1:0]        sub_r, sub_nxt;
  logic                    running_r, running_nxt;
  logic                    obstacle_r, obstacle_nxt;

  // result register
  logic                out_valid_r;
  logic                trig_r, trig_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic                obs_out_r;
  logic [SPEED_W-1:0]  duty_r;
  logic [DIR_W-1:0]    dir_r;

  logic in_accept;

  // a new tick enters whenever the result slot is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // phase length reached; lengths above the counter range act as its maximum
  function automatic logic reached(input logic [COUNTER_BITS-1:0] ticks,
                                   input logic [31:0] limit);
    return (32'(ticks) >= limit) || (ticks == CNT_MAX);
  endfunction

  // saturating tick count
  function automatic logic [COUNTER_BITS-1:0] bump(input logic [COUNTER_BITS-1:0] ticks);
    return (ticks == CNT_MAX) ? ticks : ticks + 1'b1;
  endfunction

  // one tick of the ranging cycle; a used-up phase hands over in the same tick
  always_comb begin
    logic             timed_out;
    logic [SUB_W-1:0] sub_inc;

    phase_nxt    = phase_r;
    ticks_nxt    = ticks_r;
    cm_nxt       = cm_r;
    sub_nxt      = sub_r;
    running_nxt  = running_r;
    obstacle_nxt = obstacle_r;
    trig_nxt     = 1'b0;
    status_nxt   = ST_NONE;
    dist_nxt     = '0;
    timed_out    = 1'b0;
    sub_inc      = '0;

    if (phase_nxt == PH_SETTLE) begin
      if (reached(ticks_nxt, 32'(settle_r))) begin
        phase_nxt = PH_TRIG_LOW;
        ticks_nxt = '0;
      end else begin
        ticks_nxt = bump(ticks_nxt);
      end
    end

    if (phase_nxt == PH_GAP) begin
      if (reached(ticks_nxt, 32'(gap_r))) begin
        phase_nxt = PH_TRIG_LOW;
        ticks_nxt = '0;
      end else begin
        ticks_nxt = bump(ticks_nxt);
      end
    end

    // trigger held low ahead of the pulse
    if (phase_nxt == PH_TRIG_LOW) begin
      if (32'(ticks_nxt) >= LOW_LEAD_TICKS) begin
        phase_nxt = PH_TRIG_HIGH;
        ticks_nxt = '0;
      end else begin
        ticks_nxt = bump(ticks_nxt);
      end
    end

    // trigger pulse; a zero width skips it
    if (phase_nxt == PH_TRIG_HIGH) begin
      if (32'(ticks_nxt) >= 32'(trigger_r)) begin
        phase_nxt = PH_WAIT_RISE;
        ticks_nxt = '0;
      end else begin
        trig_nxt  = 1'b1;
        ticks_nxt = bump(ticks_nxt);
      end
    end

    if (phase_nxt == PH_WAIT_RISE) begin
      if (in_ch.echo_level) begin
        phase_nxt = PH_TIME_HIGH;
        ticks_nxt = '0;
        cm_nxt    = '0;
        sub_nxt   = '0;
      end else if (reached(ticks_nxt, 32'(timeout_r))) begin
        timed_out = 1'b1;
      end else begin
        ticks_nxt = bump(ticks_nxt);
      end
    end

    // echo width: centimetres counted as ticks modulo 58, rising tick included
    if (phase_nxt == PH_TIME_HIGH) begin
      if (in_ch.echo_level) begin
        if (reached(ticks_nxt, 32'(timeout_r))) begin
          timed_out = 1'b1;
        end else begin
          ticks_nxt = bump(ticks_nxt);
          sub_inc   = sub_nxt + 1'b1;
          if (sub_inc >= CM_DIV) begin
            sub_nxt = '0;
            if (cm_nxt < CM_MAX) cm_nxt = cm_nxt + 1'b1;
          end else begin
            sub_nxt = sub_inc;
          end
        end
      end else begin
        // echo fell: decide on the measured distance
        status_nxt   = ST_VALID;
        dist_nxt     = cm_nxt;
        obstacle_nxt = (cm_nxt <= thresh_r);
        running_nxt  = !(cm_nxt <= thresh_r);
        phase_nxt    = PH_GAP;
        ticks_nxt    = '0;
      end
    end

    // no echo in time, or an echo held past the timeout: report it and keep driving forward
    if (timed_out) begin
      status_nxt   = ST_TIMEOUT;
      running_nxt  = 1'b1;
      obstacle_nxt = 1'b0;
      phase_nxt    = PH_GAP;
      ticks_nxt    = '0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      trigger_r <= TRIGGER_RST;
      gap_r     <= GAP_RST;
      settle_r  <= SETTLE_RST;
      thresh_r  <= THRESH_RST;
      speed_r   <= SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_data[TIMEOUT_W-1:0];
        CFG_TRIGGER: trigger_r <= cfg_data[TRIGGER_W-1:0];
        CFG_GAP:     gap_r     <= cfg_data[GAP_W-1:0];
        CFG_SETTLE:  settle_r  <= cfg_data[SETTLE_W-1:0];
        CFG_THRESH:  thresh_r  <= cfg_data[THRESH_W-1:0];
        CFG_SPEED:   speed_r   <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // ranging state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SETTLE;
      ticks_r     <= '0;
      cm_r        <= '0;
      sub_r       <= '0;
      running_r   <= 1'b0;
      obstacle_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r    <= phase_nxt;
        ticks_r    <= ticks_nxt;
        cm_r       <= cm_nxt;
        sub_r      <= sub_nxt;
        running_r  <= running_nxt;
        obstacle_r <= obstacle_nxt;
      end
      if (in_accept)         out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      trig_r    <= trig_nxt;
      status_r  <= status_nxt;
      dist_r    <= dist_nxt;
      obs_out_r <= obstacle_nxt;
      duty_r    <= running_nxt ? speed_r : '0;
      dir_r     <= running_nxt ? DIR_FORWARD : DIR_STOP;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.trigger_level  = trig_r;
  assign out_ch.measure_status = status_r;
  assign out_ch.range_cm       = dist_r;
  assign out_ch.obstacle       = obs_out_r;
  assign out_ch.drive_duty     = duty_r;
  assign out_ch.direction_bits = dir_r;

  // remainder counter never reaches the divisor
  `URS_ASSERT_NOW(a_sub_below_div, clk, rst_n, 1'b1, sub_r < CM_DIV)
  // echo falling while timing always closes the measurement into the gap
  `URS_ASSERT_NEXT(a_fall_to_gap, clk, rst_n,
                   in_accept && (phase_r == PH_TIME_HIGH) && !in_ch.echo_level,
                   (phase_r == PH_GAP) && (status_r == ST_VALID))
  // a result flagging an obstacle never drives the motors
  `URS_ASSERT_NOW(a_obstacle_stops, clk, rst_n, out_valid_r && obs_out_r,
                  (dir_r == DIR_STOP) && (duty_r == '0))
  // a timeout never reports an obstacle and keeps driving forward
  `URS_ASSERT_NOW(a_timeout_runs, clk, rst_n,
                  out_valid_r && (status_r == ST_TIMEOUT),
                  !obs_out_r && (dir_r == DIR_FORWARD))

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic ranger obstacle stop testbench
// drives one echo sample per tick item, mirrors the ranging cycle in a local
// predictor and checks every result item field by field, with random stalls
// on both channels and register changes between measurement episodes
// ----------------------------------------------------------------------------
module testbench;
  import urs_pkg::*;

  // hard stop
  localparam int LIMIT_CYCLES = 10_000_000;
  localparam int MAX_IDLE     = 17;
  localparam int ITEM_GOAL    = 400;
  localparam int TAIL_CYCLES  = 8;
  localparam int RETUNE_EVERY = 2;
  localparam int WIDTH_CAP    = 130;
  localparam int unsigned NEVER = 32'hFFFF_FFFF;

  // register indexes the block does not decode
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [URS_COUNTER_BITS-1:0] TICKS_MAX = '1;

  // one result item as it leaves the block
  typedef struct packed {
    logic                trigger_level;
    logic [STATUS_W-1:0] measure_status;
    logic [DIST_W-1:0]   range_cm;
    logic                obstacle;
    logic [SPEED_W-1:0]  drive_duty;
    logic [DIR_W-1:0]    direction_bits;
  } tick_result_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  // directed stimulus row: a register write, or a run of identical ticks
  typedef struct {
    row_kind_t           kind;
    cfg_idx_t            reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                echo;
    int unsigned         reps;
    bit                  typed;
    tick_result_t        want;
  } stim_row_t;

  // results that can be read straight off the spec
  localparam tick_result_t RES_QUIET = '{1'b0, ST_NONE, 11'd0, 1'b0, 8'd0, DIR_STOP};
  localparam tick_result_t RES_TMO_FULL = '{1'b0, ST_TIMEOUT, 11'd0, 1'b0, 8'hFF,
                                            DIR_FORWARD};
  localparam tick_result_t RES_NEAR_STOP = '{1'b0, ST_VALID, 11'd0, 1'b1, 8'd0, DIR_STOP};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  urs_in_if  in_bus ();
  urs_out_if out_bus ();

  ultrasonic_ranger_obstacle_stop u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [TIMEOUT_W-1:0] rng_timeout;
  logic [TRIGGER_W-1:0] rng_trigger;
  logic [GAP_W-1:0]     rng_gap;
  logic [SETTLE_W-1:0]  rng_settle;
  logic [THRESH_W-1:0]  rng_thresh;
  logic [SPEED_W-1:0]   rng_speed;

  // predictor copy of the ranging state
  phase_t                      rng_phase;
  logic [URS_COUNTER_BITS-1:0] rng_ticks;
  logic [DIST_W-1:0]           rng_cm;
  logic [SUB_W-1:0]            rng_sub;
  bit                          rng_running;
  bit                          rng_hold;

  tick_result_t tick_outputs_due [$];
  int  n_fail      = 0;
  int  n_items     = 0;
  bit  idle_in     = 1'b1;
  bit  idle_out    = 1'b1;

  // directed part: reset view, extreme register values, both timeouts,
  // zero trigger width, zero gap and settle, and a near-obstacle stop
  stim_row_t directed_rows [30] = '{
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b0, 2, 1'b1, RES_QUIET},
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b1, 1, 1'b1, RES_QUIET},
    '{ROW_WRITE, CFG_SETTLE,  20'hFFFFF, 1'b0, 0, 1'b0, '0},
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b1, 2, 1'b1, RES_QUIET},
    '{ROW_WRITE, CFG_SETTLE,  20'h0,     1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_TRIGGER, 20'h0,     1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_TIMEOUT, 20'h1,     1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_GAP,     20'h0,     1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_THRESH,  20'h0,     1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_SPEED,   20'hFF,    1'b0, 0, 1'b0, '0},
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b0, 3, 1'b0, '0},
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b0, 1, 1'b1, RES_TMO_FULL},
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b1, 3, 1'b0, '0},
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b1, 1, 1'b1, RES_TMO_FULL},
    '{ROW_WRITE, CFG_TIMEOUT, 20'hFFFF,  1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_TRIGGER, 20'h1,     1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_THRESH,  20'h7FF,   1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_SPEED,   20'h0,     1'b0, 0, 1'b0, '0},
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b0, 4, 1'b0, '0},
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b1, 1, 1'b0, '0},
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b0, 1, 1'b1, RES_NEAR_STOP},
    '{ROW_WRITE, CFG_GAP,     20'hFFFFF, 1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_THRESH,  20'h0,     1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_SPEED,   20'hA5,    1'b0, 0, 1'b0, '0},
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b1, 4, 1'b0, '0},
    '{ROW_TICK,  CFG_TIMEOUT, 20'h0,     1'b0, 4, 1'b0, '0},
    '{ROW_WRITE, CFG_GAP,     20'h3,     1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_TIMEOUT, 20'd200,   1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_THRESH,  20'h3,     1'b0, 0, 1'b0, '0},
    '{ROW_WRITE, CFG_SPEED,   20'd120,   1'b0, 0, 1'b0, '0}
  };

  function automatic void ranger_reset();
    rng_timeout = TIMEOUT_RST;
    rng_trigger = TRIGGER_RST;
    rng_gap     = GAP_RST;
    rng_settle  = SETTLE_RST;
    rng_thresh  = THRESH_RST;
    rng_speed   = SPEED_RST;
    rng_phase   = PH_SETTLE;
    rng_ticks   = '0;
    rng_cm      = '0;
    rng_sub     = '0;
    rng_running = 1'b0;
    rng_hold    = 1'b0;
  endfunction

  function automatic void enter_phase(phase_t p);
    rng_phase = p;
    rng_ticks = '0;
  endfunction

  // phase tick counter saturates instead of wrapping
  function automatic void bump_ticks();
    if (rng_ticks != TICKS_MAX) rng_ticks++;
  endfunction

  // one tick of the ranging cycle; a phase whose length is used up hands
  // over within the same tick, so the checks below run in sequence
  // (gap and settle are no wider than the tick counter, so no clamp needed)
  function automatic tick_result_t ranger_advance(logic echo);
    tick_result_t r;
    bit           timed_out;
    r = '0;
    timed_out = 1'b0;
    if (rng_phase == PH_SETTLE) begin
      if (rng_ticks >= rng_settle) enter_phase(PH_TRIG_LOW);
      else bump_ticks();
    end
    if (rng_phase == PH_GAP) begin
      if (rng_ticks >= rng_gap) enter_phase(PH_TRIG_LOW);
      else bump_ticks();
    end
    if (rng_phase == PH_TRIG_LOW) begin
      if (rng_ticks >= LOW_LEAD_TICKS) enter_phase(PH_TRIG_HIGH);
      else bump_ticks();
    end
    if (rng_phase == PH_TRIG_HIGH) begin
      if (rng_ticks >= rng_trigger) begin
        enter_phase(PH_WAIT_RISE);
      end else begin
        r.trigger_level = 1'b1;
        bump_ticks();
      end
    end
    if (rng_phase == PH_WAIT_RISE) begin
      if (echo) begin
        enter_phase(PH_TIME_HIGH);
        rng_cm  = '0;
        rng_sub = '0;
      end else if (rng_ticks >= rng_timeout) begin
        timed_out = 1'b1;
      end else begin
        bump_ticks();
      end
    end
    if (rng_phase == PH_TIME_HIGH) begin
      if (echo) begin
        if (rng_ticks >= rng_timeout) begin
          timed_out = 1'b1;
        end else begin
          // width counted as ticks modulo 58 plus whole centimetres
          bump_ticks();
          rng_sub++;
          if (rng_sub >= CM_DIV) begin
            rng_sub = '0;
            if (rng_cm != CM_MAX) rng_cm++;
          end
        end
      end else begin
        r.measure_status = ST_VALID;
        r.range_cm       = rng_cm;
        rng_hold         = (rng_cm <= rng_thresh);
        rng_running      = !rng_hold;
        enter_phase(PH_GAP);
      end
    end
    if (timed_out) begin
      r.measure_status = ST_TIMEOUT;
      rng_running      = 1'b1;
      rng_hold         = 1'b0;
      enter_phase(PH_GAP);
    end
    r.obstacle       = rng_hold;
    r.drive_duty     = rng_running ? rng_speed : '0;
    r.direction_bits = rng_running ? DIR_FORWARD : DIR_STOP;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // send one tick item after a random hold-off; the predictor steps at the
  // accepting edge, so the queue order is the acceptance order
  task automatic push_tick(input logic echo, input bit typed, input tick_result_t want,
                           output tick_result_t seen);
    int unsigned hold;
    hold = idle_in ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (hold != 0) begin
      in_bus.valid <= 1'b0;
      repeat (hold) @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.echo_level <= echo;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    seen = ranger_advance(echo);
    tick_outputs_due.push_back(typed ? want : seen);
    n_items++;
  endtask

  // stop sending and wait until every result item is back
  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (tick_outputs_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    // bits above a register's width are dropped
    case (idx)
      CFG_TIMEOUT: rng_timeout = data[TIMEOUT_W-1:0];
      CFG_TRIGGER: rng_trigger = data[TRIGGER_W-1:0];
      CFG_GAP:     rng_gap     = data[GAP_W-1:0];
      CFG_SETTLE:  rng_settle  = data[SETTLE_W-1:0];
      CFG_THRESH:  rng_thresh  = data[THRESH_W-1:0];
      CFG_SPEED:   rng_speed   = data[SPEED_W-1:0];
      default: ;
    endcase
  endtask

  // random register changes, only with the block idle; upper data bits of
  // the narrow registers carry junk on purpose
  task automatic retune_ranger();
    logic [CFG_DATA_W-1:0] word;
    int unsigned           pick;
    drain_results();
    if ($urandom_range(0, 1) == 1) begin
      word = CFG_DATA_W'($urandom);
      pick = $urandom_range(0, 15);
      case (pick)
        0:       word[TIMEOUT_W-1:0] = '0;
        1:       word[TIMEOUT_W-1:0] = TIMEOUT_W'(1);
        2:       word[TIMEOUT_W-1:0] = '1;
        3, 4:    word[TIMEOUT_W-1:0] =
                   TIMEOUT_W'($urandom_range(WIDTH_CAP + 1, 4 * WIDTH_CAP));
        default: word[TIMEOUT_W-1:0] = TIMEOUT_W'($urandom_range(2, WIDTH_CAP));
      endcase
      cfg_write(CFG_TIMEOUT, word);
    end
    if ($urandom_range(0, 1) == 1) begin
      word = CFG_DATA_W'($urandom);
      pick = $urandom_range(0, 7);
      case (pick)
        0:       word[TRIGGER_W-1:0] = '0;
        1:       word[TRIGGER_W-1:0] = '1;
        default: word[TRIGGER_W-1:0] = TRIGGER_W'($urandom_range(1, 12));
      endcase
      cfg_write(CFG_TRIGGER, word);
    end
    if ($urandom_range(0, 1) == 1) cfg_write(CFG_GAP, CFG_DATA_W'($urandom_range(0, 20)));
    // settle only matters straight after reset, so any value will do
    if ($urandom_range(0, 1) == 1) cfg_write(CFG_SETTLE, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 1) == 1) begin
      word = CFG_DATA_W'($urandom);
      pick = $urandom_range(0, 9);
      case (pick)
        0:       word[THRESH_W-1:0] = '0;
        1:       word[THRESH_W-1:0] = '1;
        2:       ;
        default: word[THRESH_W-1:0] = THRESH_W'($urandom_range(0, 2));
      endcase
      cfg_write(CFG_THRESH, word);
    end
    if ($urandom_range(0, 1) == 1) cfg_write(CFG_SPEED, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 3) == 0)
      cfg_write(CFG_INDEX_W'($urandom_range(32'(CFG_SPARE_LO), 32'(CFG_SPARE_HI))),
                CFG_DATA_W'($urandom));
  endtask

  // one trigger-to-decision episode; the echo follows the predicted phase:
  // noise outside the measurement, then a rise after a short wait and a
  // high pulse of chosen width; some episodes never rise or stay high past
  // the timeout
  task automatic range_one_ping();
    int unsigned  rise_at;
    int unsigned  width;
    int unsigned  wcap;
    int unsigned  waited;
    int unsigned  held;
    int unsigned  plan;
    logic         echo;
    tick_result_t seen;
    bit           decided;
    wcap = (rng_timeout < WIDTH_CAP) ? rng_timeout : WIDTH_CAP;
    if (wcap == 0) wcap = 1;
    rise_at = $urandom_range(0, 8);
    width   = $urandom_range(1, wcap);
    plan    = $urandom_range(0, 7);
    if (rng_timeout <= WIDTH_CAP) begin
      if (plan == 0) rise_at = NEVER;
      else if (plan == 1) width = rng_timeout + 1 + $urandom_range(0, 4);
    end
    waited  = 0;
    held    = 0;
    decided = 1'b0;
    while (!decided) begin
      case (rng_phase)
        PH_WAIT_RISE: begin
          echo = (waited >= rise_at);
          waited++;
        end
        PH_TIME_HIGH: begin
          echo = (held < width);
          held++;
        end
        default: echo = ($urandom_range(0, 5) == 0);
      endcase
      push_tick(echo, 1'b0, '0, seen);
      decided = (seen.measure_status != ST_NONE);
    end
  endtask

  // result side: random stall per result item, check against the oldest
  // prediction at the accepting edge
  initial begin
    int unsigned  stall;
    tick_result_t want;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_out ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clk);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      if (tick_outputs_due.size() == 0) begin
        $error("result item with no prediction pending");
        n_fail++;
      end else begin
        want = tick_outputs_due.pop_front();
        check_field("trigger_level", 32'(want.trigger_level),
                    32'(out_bus.trigger_level));
        check_field("measure_status", 32'(want.measure_status),
                    32'(out_bus.measure_status));
        check_field("range_cm", 32'(want.range_cm), 32'(out_bus.range_cm));
        check_field("obstacle", 32'(want.obstacle), 32'(out_bus.obstacle));
        check_field("drive_duty", 32'(want.drive_duty), 32'(out_bus.drive_duty));
        check_field("direction_bits", 32'(want.direction_bits),
                    32'(out_bus.direction_bits));
      end
    end
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    tick_result_t seen;
    int           episode;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_bus.valid      = 1'b0;
    in_bus.echo_level = 1'b0;
    out_bus.ready     = 1'b0;
    ranger_reset();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed table: writes wait for the block to go idle first
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_results();
        cfg_write(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        repeat (directed_rows[i].reps)
          push_tick(directed_rows[i].echo, directed_rows[i].typed,
                    directed_rows[i].want, seen);
      end
    end

    // random episodes, a fresh register setting every few; some episodes
    // run with no idling on one or both sides
    episode = 0;
    while (n_items < ITEM_GOAL) begin
      if (episode % RETUNE_EVERY == 0) retune_ranger();
      idle_in  = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      range_one_ping();
      episode++;
    end

    drain_results();
    // keep clocking to catch any stray result item
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_fail == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/urs_pkg.sv
rtl/urs_in_if.sv
rtl/urs_out_if.sv
rtl/ultrasonic_ranger_obstacle_stop.sv
bench/testbench.sv
